### rtl/core/lph_pkg.sv
// types and constants shared by the linear probe hash map
package lph_pkg;

    localparam int BUCKETS     = 1024;
    localparam int IDX_BITS    = $clog2(BUCKETS);
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int OCC_BITS    = IDX_BITS + 1;
    localparam int LIMIT_BITS  = 10;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = LIMIT_BITS'(819);
    localparam logic [IDX_BITS-1:0]   IDX_MAX          = IDX_BITS'(BUCKETS - 1);

    // register index taken from paddr[2]
    localparam logic REG_LOAD_LIMIT = 1'b0;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] STS_HIT     = 3'd0;
    localparam logic [2:0] STS_MISS    = 3'd1;
    localparam logic [2:0] STS_NEW     = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]            status;
        logic [VALUE_BITS-1:0] value_out;
    } t_rsp;

    typedef struct packed {
        logic [1:0]            tag;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

### rtl/core/linear_probe_hash_map.sv
// linear probe hash map: key/value table in one slot memory with a probe sequencer
//
// Request channel i_req_valid / o_req_stall carries one word {req_type, key, value};
// response channel o_rsp_valid / i_rsp_stall returns one word {status, value_out}
// per request. A word moves at a clock edge with valid high and stall low.
// Insert, delete and lookup walk the slot memory one slot per cycle from the
// home slot (low key bits) until a match, an empty slot, or all slots are seen.
// Clear sweeps every slot.
// One request is in flight at a time; the next is accepted as soon as the
// previous result has moved to the response register, even if that is stalled.
// A stalled response holds its word; a finished result waits inside until the
// response register frees up, and no new request is taken meanwhile.
// After reset the block empties the slot memory with o_req_stall high; load_limit
// resets to 819 and may be written over APB at any time the block is idle.
module linear_probe_hash_map
    import lph_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_stall,
    input  t_req                     i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_stall,
    output t_rsp                     o_rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_slot                 r_mem [BUCKETS];
    t_slot                 r_rd;
    t_state                r_state, n_state;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic [IDX_BITS-1:0]   r_cnt, n_cnt;
    t_req                  r_req, n_req;
    logic                  r_has_tomb, n_has_tomb;
    logic [IDX_BITS-1:0]   r_tomb_at, n_tomb_at;
    logic [OCC_BITS-1:0]   r_occ, n_occ;
    logic [LIMIT_BITS-1:0] r_limit;
    t_rsp                  r_res, n_res;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    t_slot                 mem_wdata;
    logic                  mem_re;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic                  out_free;
    logic                  hit;
    logic                  empt;
    logic                  tomb_now;
    logic                  tomb_seen;
    logic [IDX_BITS-1:0]   tomb_addr;
    logic                  cfg_wr;

    assign out_free  = !r_out_valid || !i_rsp_stall;
    assign hit       = (r_rd.tag == TAG_LIVE) && (r_rd.key == r_req.key);
    assign empt      = (r_rd.tag == TAG_EMPTY);
    assign tomb_now  = (r_rd.tag != TAG_EMPTY) && (r_rd.tag != TAG_LIVE);
    assign tomb_seen = r_has_tomb || tomb_now;
    assign tomb_addr = r_has_tomb ? r_tomb_at : r_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_req      = r_req;
        n_has_tomb = r_has_tomb;
        n_tomb_at  = r_tomb_at;
        n_occ      = r_occ;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '{tag: TAG_EMPTY, key: r_req.key, value: r_req.value};
        mem_re     = 1'b0;
        mem_raddr  = r_idx;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_MAX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    if (i_req.req_type == REQ_CLEAR) begin
                        n_idx   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = i_req.key[IDX_BITS-1:0];
                        n_idx      = i_req.key[IDX_BITS-1:0];
                        n_cnt      = '0;
                        n_has_tomb = 1'b0;
                        n_state    = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (hit || empt || (r_cnt == IDX_MAX)) begin
                    n_state = S_DONE;
                    n_res   = '{status: STS_MISS, value_out: '0};
                    mem_wdata.tag = TAG_LIVE;
                    case (r_req.req_type)
                        REQ_INSERT: begin
                            if (hit) begin
                                mem_we       = 1'b1;
                                n_res.status = STS_HIT;
                            end else if (tomb_seen) begin
                                mem_we       = 1'b1;
                                mem_waddr    = tomb_addr;
                                n_res.status = STS_NEW;
                            end else if (empt && (r_occ < OCC_BITS'(r_limit))) begin
                                mem_we       = 1'b1;
                                n_occ        = r_occ + 1'b1;
                                n_res.status = STS_NEW;
                            end else begin
                                n_res.status = STS_FULL;
                            end
                        end
                        REQ_DELETE: begin
                            if (hit) begin
                                mem_we        = 1'b1;
                                mem_wdata     = r_rd;
                                mem_wdata.tag = TAG_TOMB;
                                n_res.status  = STS_HIT;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (hit) begin
                                n_res.status    = STS_HIT;
                                n_res.value_out = r_rd.value;
                            end
                        end
                        default: begin
                            n_res.status = STS_MISS;
                        end
                    endcase
                end else begin
                    if (tomb_now && !r_has_tomb) begin
                        n_has_tomb = 1'b1;
                        n_tomb_at  = r_idx;
                    end
                    n_cnt     = r_cnt + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + 1'b1;
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_MAX) begin
                    n_occ   = '0;
                    n_res   = '{status: STS_CLEARED, value_out: '0};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_occ   <= n_occ;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_req      <= n_req;
        r_has_tomb <= n_has_tomb;
        r_tomb_at  <= n_tomb_at;
        r_res      <= n_res;
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    // apb register
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOAD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LOAD_LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata[LIMIT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LOAD_LIMIT)
                  ? {{(APB_DATA_BITS-LIMIT_BITS){1'b0}}, r_limit} : '0;
    assign pready = 1'b1;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_BITS'(BUCKETS))
        else $error("occupied count beyond table size");

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("slot memory read and written in one cycle");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && (r_idx == IDX_MAX) |=> (r_occ == '0))
        else $error("clear left occupied count nonzero");

    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.value_out != '0) |-> (o_rsp.status == STS_HIT))
        else $error("value returned without a hit");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> (r_state != S_IDLE))
        else $error("accepted request not started");
`endif

endmodule
